### hdl/assert_macros.svh
// Assertion macros used by the top level of the homing sequencer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hdl/idhs_pkg.sv
// Types, codes and constants of the indexed drive homing sequencer.
// No dependencies; used by idhs_div and the top level.
`default_nettype none

package idhs_pkg;

    localparam int TOO_CLOSE_WINDOW_MS = 100;
    localparam int BACKOFF_SLOTS       = 5;

    localparam int ENC_W  = 32;
    localparam int STEP_W = 16;

    localparam logic [2:0] SLOT_LAST = 3'd4;
    localparam logic [2:0] SLOT_NONE = 3'd5;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_SETUP  = 3'd1,
        M_CLOSE  = 3'd2,
        M_RETURN = 3'd3,
        M_RUN    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_TARGET = 3'd3,
        CMD_SENSOR = 3'd4,
        CMD_FORCE  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SENSOR_ENABLE  = 3'd0,
        REG_EDGE_PRESET    = 3'd1,
        REG_SENSOR_PRESET  = 3'd2,
        REG_SLOT_STEP      = 3'd3,
        REG_MAX_OFFSET     = 3'd4,
        REG_STALL_MS_SETUP = 3'd5,
        REG_STALL_MS_CLOSE = 3'd6,
        REG_RETURN_WINDOW  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ENC_W-1:0]  quot_mag;
        logic [STEP_W-1:0] rem_mag;
    } div_res_t;

endpackage

`default_nettype wire

### hdl/idhs_div.sv
// Bit-serial restoring divider: magnitude of a signed 32-bit count by a
// 16-bit step, one quotient bit per cycle. Depends on idhs_pkg.
`default_nettype none

module idhs_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [idhs_pkg::ENC_W-1:0]    dividend,
    input  wire logic [idhs_pkg::STEP_W-1:0]   divisor,
    output idhs_pkg::div_res_t                 res
);
    import idhs_pkg::*;

    localparam int CNT_W = $clog2(ENC_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ENC_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]   rem_reg, rem_next;
    logic [STEP_W:0]     rem_shift;
    logic                ge;
    logic [ENC_W-1:0]    mag;

    always_comb begin
        mag       = dividend[ENC_W-1] ? (ENC_W'(0) - dividend) : dividend;
        rem_shift = {rem_reg, quot_reg[ENC_W-1]};
        ge        = rem_shift >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = mag;
            rem_next  = '0;
        end else if (busy_reg) begin
            quot_next = {quot_reg[ENC_W-2:0], ge};
            rem_next  = ge ? STEP_W'(rem_shift - {1'b0, divisor}) : rem_shift[STEP_W-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ENC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res.busy     = busy_reg;
    assign res.done     = done_reg;
    assign res.quot_mag = quot_reg;
    assign res.rem_mag  = rem_reg;

endmodule

`default_nettype wire

### hdl/indexed_drive_homing_sequencer.sv
// Homing and position sequencer for a five-slot indexed drive.
// Input words arrive on the s_ stream (command in s_tuser; time, encoder count,
// sensor level, target slot and forced mode in s_tdata). Each word yields
// exactly one result word on the m_ stream: reference, preset request,
// mode, slot decoded from the encoder count, and control enable.
// Eight setup registers sit on the APB port at byte addresses 4*i.
// After acceptance the EXEC state updates the mode and starts the slot
// decode, which runs through a bit-serial divider (one quotient bit a
// cycle); the DONE state then loads the output register. No new word is
// taken before the last one's result is loaded; s_tready is high only while no word is in work.
// The result sits in an output register: a stalled receiver holds it and
// the block accepts the next word meanwhile, but does not finish it until
// the held result has been taken.
// Reset (aresetn low, synchronous) sets mode idle, start time and last
// encoder 0, last change time 0xFFFF, reference 0, and the registers to
// their defaults. Depends on idhs_pkg, idhs_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module indexed_drive_homing_sequencer #(
    parameter int CLOSE_WINDOW_MS = idhs_pkg::TOO_CLOSE_WINDOW_MS,
    parameter int BACKOFF_COUNT   = idhs_pkg::BACKOFF_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] time_ms, [63:32] encoder_count, [64] sensor_level,
    // [67:65] target_slot, [70:68] forced_mode, [71] zero
    input  wire logic [71:0] s_tdata,
    // [2:0] command
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] reference, [32] preset_valid, [49:33] preset_value,
    // [52:50] mode, [55:53] slot, [56] control_enable, [63:57] zero
    output logic [63:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import idhs_pkg::*;

    // configuration
    logic        sensor_enable_reg;
    logic [15:0] edge_preset_reg, sensor_preset_reg, slot_step_reg, max_offset_reg;
    logic [15:0] stall_ms_setup_reg, stall_ms_close_reg;
    logic [16:0] return_window_reg;
    logic        cfg_wr;

    // captured word
    logic [2:0]  cmd_reg;
    logic [31:0] time_reg;
    logic [31:0] enc_reg;
    logic        level_reg;
    logic [2:0]  target_reg, forced_reg;

    // sequencer state
    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] last_encoder_reg, last_encoder_next;
    logic [31:0] last_change_time_reg, last_change_time_next;
    logic [31:0] reference_reg, reference_next;
    logic        preset_valid_reg, preset_valid_next;
    logic [16:0] preset_value_reg, preset_value_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg;

    logic        accept, exec_en, div_start, load_out;
    div_res_t    div_res;

    // tick arithmetic
    logic [31:0]        elapsed, setup_ref, stall_lim_setup, stall_lim_close;
    logic               enc_changed, stall_setup, stall_close, too_close, below_window;
    logic signed [20:0] tgt_off_w, step_w, tgt_ref;
    logic [20:0]        backoff_mag;
    logic [2:0]         slot;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_enable_reg  <= 1'b0;
            edge_preset_reg    <= 16'd1950;
            sensor_preset_reg  <= 16'd1400;
            slot_step_reg      <= 16'd780;
            max_offset_reg     <= 16'd156;
            stall_ms_setup_reg <= 16'd100;
            stall_ms_close_reg <= 16'd70;
            return_window_reg  <= 17'd50;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SENSOR_ENABLE:  sensor_enable_reg  <= pwdata[0];
                REG_EDGE_PRESET:    edge_preset_reg    <= pwdata[15:0];
                REG_SENSOR_PRESET:  sensor_preset_reg  <= pwdata[15:0];
                REG_SLOT_STEP:      slot_step_reg      <= pwdata[15:0];
                REG_MAX_OFFSET:     max_offset_reg     <= pwdata[15:0];
                REG_STALL_MS_SETUP: stall_ms_setup_reg <= pwdata[15:0];
                REG_STALL_MS_CLOSE: stall_ms_close_reg <= pwdata[15:0];
                REG_RETURN_WINDOW:  return_window_reg  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SENSOR_ENABLE:  prdata = {31'b0, sensor_enable_reg};
            REG_EDGE_PRESET:    prdata = {16'b0, edge_preset_reg};
            REG_SENSOR_PRESET:  prdata = {16'b0, sensor_preset_reg};
            REG_SLOT_STEP:      prdata = {16'b0, slot_step_reg};
            REG_MAX_OFFSET:     prdata = {16'b0, max_offset_reg};
            REG_STALL_MS_SETUP: prdata = {16'b0, stall_ms_setup_reg};
            REG_STALL_MS_CLOSE: prdata = {16'b0, stall_ms_close_reg};
            REG_RETURN_WINDOW:  prdata = {15'b0, return_window_reg};
            default:            prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DIV;
            ST_DIV:  if (div_res.done) state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_en   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EXEC: begin
                exec_en   = 1'b1;
                div_start = 1'b1;
            end
            ST_DONE: load_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        elapsed         = time_reg - start_time_reg;
        setup_ref       = elapsed[31] ? 32'h7FFF_FFFF : elapsed;
        too_close       = elapsed < 32'(CLOSE_WINDOW_MS);
        enc_changed     = enc_reg != last_encoder_reg;
        stall_lim_setup = last_change_time_reg + {16'b0, stall_ms_setup_reg};
        stall_lim_close = last_change_time_reg + {16'b0, stall_ms_close_reg};
        stall_setup     = !enc_changed && (stall_lim_setup < time_reg);
        stall_close     = !enc_changed && (stall_lim_close < time_reg);
        below_window    = $signed(enc_reg) < $signed({{15{return_window_reg[16]}},
                                                      return_window_reg});
        tgt_off_w       = $signed({18'b0, target_reg}) - 21'sd2;
        step_w          = $signed({5'b0, slot_step_reg});
        tgt_ref         = tgt_off_w * step_w;
        backoff_mag     = 21'(slot_step_reg) * 21'(BACKOFF_COUNT);
    end

    always_comb begin
        mode_next             = mode_reg;
        start_time_next       = start_time_reg;
        last_encoder_next     = last_encoder_reg;
        last_change_time_next = last_change_time_reg;
        reference_next        = reference_reg;
        preset_valid_next     = 1'b0;
        preset_value_next     = '0;
        case (cmd_reg)
            CMD_TICK: begin
                case (mode_reg)
                    M_SETUP: begin
                        if (!level_reg && sensor_enable_reg) begin
                            if (too_close) begin
                                mode_next = M_CLOSE;
                            end else begin
                                preset_valid_next = 1'b1;
                                preset_value_next = {1'b0, sensor_preset_reg};
                                reference_next    = '0;
                                mode_next         = M_RETURN;
                            end
                        end else begin
                            reference_next = setup_ref;
                            if (enc_changed) begin
                                last_encoder_next     = enc_reg;
                                last_change_time_next = time_reg;
                            end else if (stall_setup) begin
                                preset_valid_next = 1'b1;
                                preset_value_next = {1'b0, edge_preset_reg};
                                reference_next    = '0;
                                mode_next         = M_RETURN;
                            end
                        end
                    end
                    M_CLOSE: begin
                        if (!level_reg) begin
                            reference_next = 32'(0) - {11'b0, backoff_mag};
                            if (enc_changed) begin
                                last_encoder_next     = enc_reg;
                                last_change_time_next = time_reg;
                            end else if (stall_close) begin
                                preset_valid_next = 1'b1;
                                preset_value_next = 17'(0) - {1'b0, edge_preset_reg};
                                reference_next    = '0;
                                mode_next         = M_RETURN;
                            end
                        end else begin
                            mode_next = M_SETUP;
                        end
                    end
                    M_RETURN: begin
                        if (below_window) mode_next = M_RUN;
                        else reference_next = '0;
                    end
                    default: ;
                endcase
            end
            CMD_START: begin
                mode_next       = M_SETUP;
                start_time_next = time_reg;
            end
            CMD_STOP: mode_next = M_IDLE;
            CMD_TARGET: begin
                if (target_reg <= SLOT_LAST) begin
                    reference_next = 32'(tgt_ref);
                end
            end
            CMD_SENSOR: begin
                if (mode_reg == M_SETUP) begin
                    preset_valid_next = 1'b1;
                    preset_value_next = {1'b0, sensor_preset_reg};
                    reference_next    = '0;
                    mode_next         = M_RETURN;
                end
            end
            CMD_FORCE: begin
                if (forced_reg <= 3'(M_RUN)) mode_next = mode_t'(forced_reg);
            end
            default: ;
        endcase
    end

    // slot from the divider result
    always_comb begin
        slot = SLOT_NONE;
        if (slot_step_reg != '0) begin
            if (enc_reg[31]) begin
                if (div_res.quot_mag <= 32'd2) slot = 3'd2 - div_res.quot_mag[2:0];
            end else if (div_res.rem_mag <= max_offset_reg) begin
                if (div_res.quot_mag <= 32'd2) slot = 3'd2 + div_res.quot_mag[2:0];
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            mode_reg             <= M_IDLE;
            start_time_reg       <= '0;
            last_encoder_reg     <= '0;
            last_change_time_reg <= 32'h0000_FFFF;
            reference_reg        <= '0;
            preset_valid_reg     <= 1'b0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_en) begin
                mode_reg             <= mode_next;
                start_time_reg       <= start_time_next;
                last_encoder_reg     <= last_encoder_next;
                last_change_time_reg <= last_change_time_next;
                reference_reg        <= reference_next;
                preset_valid_reg     <= preset_valid_next;
            end
        end
        if (exec_en) preset_value_reg <= preset_value_next;
        if (accept) begin
            cmd_reg    <= s_tuser;
            time_reg   <= s_tdata[31:0];
            enc_reg    <= s_tdata[63:32];
            level_reg  <= s_tdata[64];
            target_reg <= s_tdata[67:65];
            forced_reg <= s_tdata[70:68];
        end
        if (load_out) begin
            m_tdata_reg <= {7'b0, mode_reg != M_IDLE, slot, mode_reg,
                            preset_value_reg, preset_valid_reg, reference_reg};
        end
    end

    idhs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (enc_reg),
        .divisor  (slot_step_reg),
        .res      (div_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPLIES(a_div_runs, aclk, aresetn, state_reg == ST_DIV, div_res.busy || div_res.done)
    `ASSERT_IMPLIES(a_preset_return, aclk, aresetn, m_tvalid && m_tdata[32], m_tdata[52:50] == M_RETURN)
    `ASSERT_IMPLIES(a_no_preset_zero, aclk, aresetn, m_tvalid && !m_tdata[32], m_tdata[49:33] == 17'd0)
    `ASSERT_IMPLIES(a_enable_mode, aclk, aresetn, m_tvalid, m_tdata[56] == (m_tdata[52:50] != M_IDLE))

endmodule

`default_nettype wire
